>>> rtl/egbr_pkg.sv
// egbr_pkg: shared types and constants of the exp-golomb bitstream reader
// operation codes, result status codes, datapath command and status word
// no dependencies
package egbr_pkg;

    // command operation codes
    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_GET   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_SKIP  = 3'd3,
        OP_ALIGN = 3'd4,
        OP_UGOL  = 3'd5,
        OP_SGOL  = 3'd6,
        OP_TRAIL = 3'd7
    } op_t;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PREFIX   = 3'd1;
    localparam logic [2:0] ST_UNDERRUN = 3'd2;
    localparam logic [2:0] ST_TRAIL    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // window storage and field limits
    localparam int          WIN_W      = 64;
    localparam logic [5:0]  MAX_BITS   = 6'd32;
    localparam logic [4:0]  MLZ_RESET  = 5'd20;

    // datapath micro-commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_PUSH,
        CMD_REFILL,
        CMD_TAKE,
        CMD_ALIGN,
        CMD_PREFIX_BIT,
        CMD_UNDER,
        CMD_SUFFIX,
        CMD_FORM,
        CMD_SIGN,
        CMD_TRAIL_FIRST,
        CMD_TRAIL_SCAN
    } cmd_t;

    // datapath status seen by the controller
    typedef struct packed {
        op_t  op;
        logic n_zero;
        logic need_refill;
        logic can_refill;
        logic fill_empty;
        logic queue_empty;
        logic top_bit;
        logic zeros_zero;
        logic zeros_at_limit;
    } stat_t;

endpackage

>>> rtl/egbr_queue.sv
// egbr_queue: circular byte queue with a prefetching registered read port
// the read data always shows the byte at the read pointer
// depends on nothing but its parameter
module egbr_queue #(
    parameter int QUEUE_BYTES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] push_byte,
    input  logic       pop,
    output logic [7:0] rd_byte,
    output logic       empty,
    output logic       full
);

    localparam int PTR_W = $clog2(QUEUE_BYTES);
    localparam int CNT_W = $clog2(QUEUE_BYTES + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_BYTES);

    logic [7:0]       mem [QUEUE_BYTES];
    logic [7:0]       rd_byte_reg;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer and count updates, wrap at the queue depth
    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        if (pop)
        begin
            rp_next    = (rp_reg == PTR_LAST) ? '0 : rp_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
        if (push)
        begin
            wp_next    = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg    <= '0;
            wp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
        end
    end

    // storage, read ahead at the next read pointer, write-through on a hit
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_byte;
        if (push && (wp_reg == rp_next))
            rd_byte_reg <= push_byte;
        else
            rd_byte_reg <= mem[rp_next];
    end

    assign rd_byte = rd_byte_reg;
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_FULL);

endmodule

>>> rtl/egbr_datapath.sv
// egbr_datapath: bit window, byte queue, prefix counter and result registers
// executes one micro-command per cycle from the controller
// depends on egbr_pkg and egbr_queue
module egbr_datapath #(
    parameter int QUEUE_BYTES = 1024,
    parameter int WINDOW_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  egbr_pkg::cmd_t      cmd,
    output egbr_pkg::stat_t     stat,
    input  logic [2:0]          operation,
    input  logic [7:0]          byte_in,
    input  logic [5:0]          bit_count,
    input  logic                cfg_write,
    input  logic [4:0]          cfg_wdata,
    output logic [31:0]         value,
    output logic signed [31:0]  signed_value,
    output logic [2:0]          status
);

    import egbr_pkg::*;

    localparam logic [6:0] FILL_LIMIT = 7'(WINDOW_BITS - 8);

    op_t               op_reg, op_next;
    logic [5:0]        n_reg, n_next;
    logic [7:0]        byte_reg, byte_next;
    logic [5:0]        zeros_reg, zeros_next;
    logic [WIN_W-1:0]  window_reg, window_next;
    logic [6:0]        fill_reg, fill_next;
    logic [4:0]        mlz_reg;
    logic [31:0]       value_reg, value_next;
    logic [31:0]       sval_reg, sval_next;
    logic [2:0]        status_reg, status_next;

    logic              q_push, q_pop, q_empty, q_full;
    logic [7:0]        q_byte;

    logic              golomb;
    logic [5:0]        take_len;
    logic [31:0]       take_val;
    logic              take_short;
    logic [WIN_W-1:0]  window_taken;
    logic [6:0]        fill_taken;
    logic [2:0]        align_k;
    logic              top_byte_zero;
    logic [31:0]       half_code;
    logic [31:0]       suffix_mask;

    egbr_queue #(
        .QUEUE_BYTES(QUEUE_BYTES)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_byte(byte_reg),
        .pop      (q_pop),
        .rd_byte  (q_byte),
        .empty    (q_empty),
        .full     (q_full)
    );

    assign q_push = (cmd == CMD_PUSH) && !q_full;
    assign q_pop  = (cmd == CMD_REFILL);

    // shared take unit: top bits of the window and the consumed window
    assign golomb       = (op_reg == OP_UGOL) || (op_reg == OP_SGOL);
    assign take_len     = golomb ? zeros_reg : n_reg;
    assign take_val     = window_reg[WIN_W-1 -: 32] >> (MAX_BITS - take_len);
    assign take_short   = fill_reg < 7'(take_len);
    assign window_taken = window_reg << take_len;
    assign fill_taken   = fill_reg - 7'(take_len);

    assign align_k       = fill_reg[2:0];
    assign top_byte_zero = (window_reg[WIN_W-1 -: 8] == 8'd0);
    assign half_code     = value_reg >> 1;
    assign suffix_mask   = (32'd1 << zeros_reg[4:0]) - 32'd1;

    // status word for the controller
    always_comb
    begin
        stat.op             = op_reg;
        stat.n_zero         = (n_reg == 6'd0);
        stat.need_refill    = take_short && !q_empty;
        stat.can_refill     = (fill_reg <= FILL_LIMIT) && !q_empty;
        stat.fill_empty     = (fill_reg == 7'd0);
        stat.queue_empty    = q_empty;
        stat.top_bit        = window_reg[WIN_W-1];
        stat.zeros_zero     = (zeros_reg == 6'd0);
        stat.zeros_at_limit = (zeros_reg >= {1'b0, mlz_reg});
    end

    // micro-command execution
    always_comb
    begin
        op_next     = op_reg;
        n_next      = n_reg;
        byte_next   = byte_reg;
        zeros_next  = zeros_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        value_next  = value_reg;
        sval_next   = sval_reg;
        status_next = status_reg;
        unique case (cmd)
            CMD_NONE:
            begin
            end
            CMD_LOAD:
            begin
                op_next     = op_t'(operation);
                n_next      = (bit_count > MAX_BITS) ? MAX_BITS : bit_count;
                byte_next   = byte_in;
                zeros_next  = '0;
                value_next  = '0;
                sval_next   = '0;
                status_next = ST_OK;
            end
            CMD_PUSH:
            begin
                if (q_full)
                    status_next = ST_FULL;
            end
            CMD_REFILL:
            begin
                window_next = window_reg | ({q_byte, 56'd0} >> fill_reg);
                fill_next   = fill_reg + 7'd8;
            end
            CMD_TAKE:
            begin
                if (op_reg != OP_SKIP)
                    value_next = take_val;
                if (take_short)
                    status_next = ST_UNDERRUN;
                if (op_reg != OP_PEEK)
                begin
                    window_next = take_short ? '0 : window_taken;
                    fill_next   = take_short ? '0 : fill_taken;
                end
            end
            CMD_ALIGN:
            begin
                window_next = window_reg << align_k;
                fill_next   = fill_reg - 7'(align_k);
            end
            CMD_PREFIX_BIT:
            begin
                window_next = window_reg << 1;
                fill_next   = fill_reg - 7'd1;
                if (!window_reg[WIN_W-1])
                begin
                    zeros_next = zeros_reg + 6'd1;
                    if (stat.zeros_at_limit)
                        status_next = ST_PREFIX;
                end
            end
            CMD_UNDER:
            begin
                status_next = ST_UNDERRUN;
            end
            CMD_SUFFIX:
            begin
                value_next  = take_val;
                if (take_short)
                    status_next = ST_UNDERRUN;
                window_next = take_short ? '0 : window_taken;
                fill_next   = take_short ? '0 : fill_taken;
            end
            CMD_FORM:
            begin
                value_next = value_reg + suffix_mask;
            end
            CMD_SIGN:
            begin
                sval_next = value_reg[0] ? (half_code + 32'd1) : (32'd0 - half_code);
            end
            CMD_TRAIL_FIRST:
            begin
                window_next = window_reg << 1;
                fill_next   = fill_reg - 7'd1;
                if (!window_reg[WIN_W-1])
                    status_next = ST_TRAIL;
            end
            CMD_TRAIL_SCAN:
            begin
                // a zero top byte is skipped whole, else one bit goes
                if (top_byte_zero)
                begin
                    window_next = window_reg << 8;
                    fill_next   = (fill_reg < 7'd8) ? 7'd0 : fill_reg - 7'd8;
                end
                else
                begin
                    window_next = window_reg << 1;
                    fill_next   = fill_reg - 7'd1;
                    if (window_reg[WIN_W-1])
                        status_next = ST_TRAIL;
                end
            end
            default:
            begin
            end
        endcase
    end

    // window and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= OP_PUSH;
            n_reg      <= '0;
            zeros_reg  <= '0;
            window_reg <= '0;
            fill_reg   <= '0;
            mlz_reg    <= MLZ_RESET;
        end
        else
        begin
            op_reg     <= op_next;
            n_reg      <= n_next;
            zeros_reg  <= zeros_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            if (cfg_write)
                mlz_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        value_reg  <= value_next;
        sval_reg   <= sval_next;
        status_reg <= status_next;
    end

    assign value        = value_reg;
    assign signed_value = $signed(sval_reg);
    assign status       = status_reg;

endmodule

>>> rtl/egbr_ctrl.sv
// egbr_ctrl: command sequencer of the exp-golomb bitstream reader
// issues datapath micro-commands, owns busy and the done strobe
// depends on egbr_pkg
module egbr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output egbr_pkg::cmd_t  cmd,
    input  egbr_pkg::stat_t stat
);

    import egbr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TAKE,
        S_REFILL,
        S_PREFIX,
        S_SUFFIX,
        S_FORM,
        S_SIGN,
        S_TRAIL_FIRST,
        S_TRAIL_SCAN
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;
    logic   finish;

    // next state and micro-command
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = CMD_NONE;
        finish     = 1'b0;
        busy_next  = busy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISPATCH;
                    busy_next  = 1'b1;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.op)
                    OP_PUSH:
                    begin
                        cmd    = CMD_PUSH;
                        finish = 1'b1;
                    end
                    OP_GET, OP_PEEK, OP_SKIP:
                    begin
                        priority if (stat.n_zero)
                            finish = 1'b1;
                        else if (stat.need_refill)
                        begin
                            ret_next   = S_TAKE;
                            state_next = S_REFILL;
                        end
                        else
                        begin
                            cmd    = CMD_TAKE;
                            finish = 1'b1;
                        end
                    end
                    OP_ALIGN:
                    begin
                        cmd    = CMD_ALIGN;
                        finish = 1'b1;
                    end
                    OP_UGOL, OP_SGOL:
                        state_next = S_PREFIX;
                    OP_TRAIL:
                        state_next = S_TRAIL_FIRST;
                    default:
                        finish = 1'b1;
                endcase
            end
            S_TAKE:
            begin
                cmd    = CMD_TAKE;
                finish = 1'b1;
            end
            S_REFILL:
            begin
                // one byte a cycle until the window or the queue runs out
                if (stat.can_refill)
                    cmd = CMD_REFILL;
                else
                    state_next = ret_reg;
            end
            S_PREFIX:
            begin
                priority if (stat.fill_empty && stat.queue_empty)
                begin
                    cmd    = CMD_UNDER;
                    finish = 1'b1;
                end
                else if (stat.fill_empty)
                begin
                    ret_next   = S_PREFIX;
                    state_next = S_REFILL;
                end
                else
                begin
                    cmd = CMD_PREFIX_BIT;
                    priority if (stat.top_bit && stat.zeros_zero)
                        finish = 1'b1;
                    else if (stat.top_bit)
                        state_next = S_SUFFIX;
                    else if (stat.zeros_at_limit)
                        finish = 1'b1;
                    else
                        state_next = S_PREFIX;
                end
            end
            S_SUFFIX:
            begin
                if (stat.need_refill)
                begin
                    ret_next   = S_SUFFIX;
                    state_next = S_REFILL;
                end
                else
                begin
                    cmd        = CMD_SUFFIX;
                    state_next = S_FORM;
                end
            end
            S_FORM:
            begin
                cmd = CMD_FORM;
                if (stat.op == OP_SGOL)
                    state_next = S_SIGN;
                else
                    finish = 1'b1;
            end
            S_SIGN:
            begin
                cmd    = CMD_SIGN;
                finish = 1'b1;
            end
            S_TRAIL_FIRST:
            begin
                priority if (stat.fill_empty && stat.queue_empty)
                begin
                    cmd    = CMD_UNDER;
                    finish = 1'b1;
                end
                else if (stat.fill_empty)
                begin
                    ret_next   = S_TRAIL_FIRST;
                    state_next = S_REFILL;
                end
                else
                begin
                    cmd = CMD_TRAIL_FIRST;
                    if (stat.top_bit)
                        state_next = S_TRAIL_SCAN;
                    else
                        finish = 1'b1;
                end
            end
            S_TRAIL_SCAN:
            begin
                priority if (stat.fill_empty && stat.queue_empty)
                    finish = 1'b1;
                else if (stat.fill_empty)
                begin
                    ret_next   = S_TRAIL_SCAN;
                    state_next = S_REFILL;
                end
                else
                begin
                    // a one bit ends the scan, unless it sits under a zero top byte
                    cmd = CMD_TRAIL_SCAN;
                    if (stat.top_bit)
                        finish = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (finish)
        begin
            state_next = S_IDLE;
            busy_next  = 1'b0;
        end
        done_next = finish;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

>>> rtl/bitstream_expgolomb_reader.sv
// bitstream_expgolomb_reader: top level of the exp-golomb bitstream reader
// joins the command sequencer and the window/queue datapath
// depends on egbr_pkg, egbr_ctrl, egbr_datapath
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+----------------------------
//   command  | operation, byte_in, bit_count             | taken on start && !busy
//   result   | value, signed_value, status               | done strobe, one cycle
//   config   | cfg_wdata (max_leading_zeros)             | written on cfg_write
//
// push, align, and get/peek/skip with enough window bits finish straight from dispatch.
// a window refill moves bytes from the queue until the window has no room for a byte
// or the queue is empty; the queue read port moves one byte per cycle in a refill.
// golomb decode: prefix bits one at a time, then suffix and sum when the prefix
// has a zero, then the signed mapping for signed; a refill may come in between.
// trailing check scans one bit, or a whole zero byte, per cycle between refills.
// async active-low reset; no clearing pass, queue contents are undefined until
// pushed. results are never stalled: done marks each word for one cycle.
module bitstream_expgolomb_reader #(
    parameter int QUEUE_BYTES = 1024,
    parameter int WINDOW_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic [7:0]         byte_in,
    input  logic [5:0]         bit_count,
    input  logic               cfg_write,
    input  logic [4:0]         cfg_wdata,
    output logic               done,
    output logic [31:0]        value,
    output logic signed [31:0] signed_value,
    output logic [2:0]         status
);

    import egbr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    egbr_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .done (done),
        .cmd  (cmd),
        .stat (stat)
    );

    egbr_datapath #(
        .QUEUE_BYTES(QUEUE_BYTES),
        .WINDOW_BITS(WINDOW_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .byte_in     (byte_in),
        .bit_count   (bit_count),
        .cfg_write   (cfg_write),
        .cfg_wdata   (cfg_wdata),
        .value       (value),
        .signed_value(signed_value),
        .status      (status)
    );

endmodule

>>> rtl/egbr_checker.sv
// egbr_checker: port-level assertions for the exp-golomb bitstream reader
// bound to the top level below
// depends on egbr_pkg and the bitstream_expgolomb_reader ports
module egbr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [2:0]         operation,
    input logic [7:0]         byte_in,
    input logic [5:0]         bit_count,
    input logic               cfg_write,
    input logic [4:0]         cfg_wdata,
    input logic               done,
    input logic [31:0]        value,
    input logic signed [31:0] signed_value,
    input logic [2:0]         status
);

    import egbr_pkg::*;

    // a result word appears only once the command has retired
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted command always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // busy never rises without a command
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");

    // status codes stay in the defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_PREFIX || status == ST_UNDERRUN ||
                  status == ST_TRAIL || status == ST_FULL))
        else $error("undefined status code");

endmodule

bind bitstream_expgolomb_reader egbr_checker u_checker (.*);
